/* rtl/core/tdpt_pkg.sv */
// Package for the trial-division prime test: default width, microcode step
// codes, control word types and the microcode table. No dependencies.
`default_nettype none

package tdpt_pkg;

    localparam int NUMBER_BITS_DEF = 32;

    localparam int STEP_W = 3;

    // Microcode step addresses.
    localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_LOOP   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DIV    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_REMCHK = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DONE   = 3'd5;

    typedef enum logic [2:0] {
        COND_IN_VALID = 3'd0,
        COND_TRIVIAL  = 3'd1,
        COND_SQ_GT    = 3'd2,
        COND_DIV_LAST = 3'd3,
        COND_REM_ZERO = 3'd4,
        COND_OUT_FREE = 3'd5
    } t_cond;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_LOAD     = 3'd1,
        ACT_RES0     = 3'd2,
        ACT_RES1     = 3'd3,
        ACT_DIV_INIT = 3'd4,
        ACT_DIV_STEP = 3'd5,
        ACT_NEXT_D   = 3'd6,
        ACT_PUSH     = 3'd7
    } t_act;

    // One control word: the input ready bit, a condition, and the action and
    // next step for each outcome of that condition.
    typedef struct packed {
        logic              in_rdy;
        t_cond             cond;
        t_act              act_t;
        logic [STEP_W-1:0] tgt_t;
        t_act              act_f;
        logic [STEP_W-1:0] tgt_f;
    } t_uword;

    function automatic t_uword uc_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            STEP_IDLE:   w = '{1'b1, COND_IN_VALID, ACT_LOAD, STEP_CHECK,
                               ACT_NONE, STEP_IDLE};
            STEP_CHECK:  w = '{1'b0, COND_TRIVIAL, ACT_RES0, STEP_DONE,
                               ACT_NONE, STEP_LOOP};
            STEP_LOOP:   w = '{1'b0, COND_SQ_GT, ACT_RES1, STEP_DONE,
                               ACT_DIV_INIT, STEP_DIV};
            STEP_DIV:    w = '{1'b0, COND_DIV_LAST, ACT_DIV_STEP, STEP_REMCHK,
                               ACT_DIV_STEP, STEP_DIV};
            STEP_REMCHK: w = '{1'b0, COND_REM_ZERO, ACT_RES0, STEP_DONE,
                               ACT_NEXT_D, STEP_LOOP};
            STEP_DONE:   w = '{1'b0, COND_OUT_FREE, ACT_PUSH, STEP_IDLE,
                               ACT_NONE, STEP_DONE};
            default:     w = '{1'b0, COND_OUT_FREE, ACT_NONE, STEP_IDLE,
                               ACT_NONE, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tdpt_cand_if.sv */
// Input channel interface of the prime test: valid, ready and one candidate.
// Depends on tdpt_pkg for the default width.
`default_nettype none

interface tdpt_cand_if
    import tdpt_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [NUMBER_BITS-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

`default_nettype wire

/* rtl/core/tdpt_res_if.sv */
// Result channel interface of the prime test: valid, ready and the flag.
// No dependencies.
`default_nettype none

interface tdpt_res_if;
    logic valid;
    logic ready;
    logic prime_flag;

    modport source (output valid, output prime_flag, input ready);
    modport sink   (input valid, input prime_flag, output ready);
endinterface

`default_nettype wire

/* rtl/core/trial_division_prime_test.sv */
// Trial-division prime test, top level. Uses tdpt_pkg for the microcode
// table and the tdpt_cand_if / tdpt_res_if channel interfaces.
//
// Usage: a word on i_cand carries one signed candidate; exactly one word
// comes back on o_res with prime_flag set when the candidate is prime.
// Negative values, zero and one give a flag of zero.
// i_cand.ready is high only while the sequencer waits in its idle step, so
// one candidate is worked on at a time. Steps per candidate, N being
// NUMBER_BITS: load, screen trivial values, then for each trial divisor a
// bound check, N-1 restoring divide steps on the shared remainder unit and
// a zero test; one last bound check when no divisor divides the value, and
// a final step to hand the flag to the output register. The divide loop
// dominates the run time: about 46,340 divisors for a large 32-bit prime.
// The flag sits in an output register, so a stalled receiver does not hold
// the block: it takes the next candidate and only waits at the end if the
// previous word has still not been taken.
// Synchronous active-low reset returns the sequencer to idle and empties
// the output register; no other state persists between candidates.
`default_nettype none

module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    tdpt_cand_if.sink      i_cand,
    tdpt_res_if.source     o_res
);

    localparam int N  = NUMBER_BITS;
    localparam int CW = $clog2(N);

    // Sequencer and output register.
    logic [STEP_W-1:0] r_pc, n_pc;
    logic              r_ovld, n_ovld;
    logic              r_flag, n_flag;

    // Datapath: value, divisor, divisor squared, remainder unit.
    logic [N-1:0]   r_v, n_v;
    logic [N-1:0]   r_d, n_d;
    logic [N:0]     r_sq, n_sq;
    logic [N-1:0]   r_rem, n_rem;
    logic [N-2:0]   r_dvd, n_dvd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_res, n_res;

    t_uword        uw;
    logic          cond;
    t_act          act;
    logic [N-1:0]  trial;

    assign uw  = uc_rom(r_pc);
    assign act = cond ? uw.act_t : uw.act_f;

    always_comb begin
        case (uw.cond)
            COND_IN_VALID: cond = i_cand.valid;
            COND_TRIVIAL:  cond = r_v[N-1] || (r_v <= N'(1));
            COND_SQ_GT:    cond = r_sq > {1'b0, r_v};
            COND_DIV_LAST: cond = (r_cnt == CW'(N - 2));
            COND_REM_ZERO: cond = (r_rem == '0);
            COND_OUT_FREE: cond = !r_ovld || o_res.ready;
            default:       cond = 1'b0;
        endcase
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign trial = {r_rem[N-2:0], r_dvd[N-2]};

    always_comb begin
        n_pc   = cond ? uw.tgt_t : uw.tgt_f;
        n_v    = r_v;
        n_d    = r_d;
        n_sq   = r_sq;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_cnt  = r_cnt;
        n_res  = r_res;
        n_flag = r_flag;
        n_ovld = r_ovld && !o_res.ready;
        unique case (act)
            ACT_NONE: begin
            end
            ACT_LOAD: begin
                n_v  = i_cand.candidate;
                n_d  = N'(2);
                n_sq = (N+1)'(4);
            end
            ACT_RES0: n_res = 1'b0;
            ACT_RES1: n_res = 1'b1;
            ACT_DIV_INIT: begin
                n_rem = '0;
                n_dvd = r_v[N-2:0];
                n_cnt = '0;
            end
            ACT_DIV_STEP: begin
                n_rem = (trial >= r_d) ? trial - r_d : trial;
                n_dvd = {r_dvd[N-3:0], 1'b0};
                n_cnt = r_cnt + CW'(1);
            end
            ACT_NEXT_D: begin
                // (d+1)^2 = d^2 + 2d + 1
                n_d  = r_d + N'(1);
                n_sq = r_sq + {r_d, 1'b1};
            end
            ACT_PUSH: begin
                n_ovld = 1'b1;
                n_flag = r_res;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= STEP_IDLE;
            r_ovld <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v    <= n_v;
        r_d    <= n_d;
        r_sq   <= n_sq;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
        r_flag <= n_flag;
    end

    assign i_cand.ready     = uw.in_rdy;
    assign o_res.valid      = r_ovld;
    assign o_res.prime_flag = r_flag;

    // An accepted candidate is always screened in the very next cycle.
    a_load_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cand.valid && i_cand.ready) |=> (r_pc == STEP_CHECK))
        else $error("accepted candidate did not move to the screening step");

    // A negative value goes straight to the output step with a zero result.
    a_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_CHECK && r_v[N-1]) |=> (r_pc == STEP_DONE && !r_res))
        else $error("negative candidate was not rejected");

    // The restoring divider keeps its partial remainder below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_DIV || r_pc == STEP_REMCHK) |-> (r_rem < r_d))
        else $error("partial remainder reached the divisor");

endmodule

`default_nettype wire
